### sv/csvft_pkg.sv
// ----------------------------------------------------------------------------
// csvft_pkg
// Types and constants shared by the CSV field tokenizer.
// ----------------------------------------------------------------------------
package csvft_pkg;

	typedef enum logic [2:0] {
		KIND_DATA   = 3'd0,
		KIND_FIELD  = 3'd1,
		KIND_RECORD = 3'd2,
		KIND_STREAM = 3'd3,
		KIND_ERROR  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		MODE_PLAIN  = 2'd0,
		MODE_QUOTED = 2'd1,
		MODE_QSEEN  = 2'd2
	} mode_t;

	// register indexes, taken from paddr[2]
	localparam logic REG_SEPARATOR = 1'b0;
	localparam logic REG_QUOTE     = 1'b1;

	localparam logic [7:0] SEPARATOR_RESET = 8'h3B;
	localparam logic [7:0] QUOTE_RESET     = 8'h22;
	localparam logic [7:0] NEWLINE_BYTE    = 8'h0A;

endpackage

### sv/csv_field_tokenizer_top.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer_top
// Splits a byte stream into field bytes, field ends, record ends, stream
// ends and open-quote errors, with quoted spans and doubled-quote escapes.
// ----------------------------------------------------------------------------
// One input transfer per clock sustained unless m_tready stalls the output.
// Each byte passes an input register, then the parse mode, field counter and
// record flag are updated as the byte moves into the result register; that
// per-byte update sets the one-byte-per-cycle rate. A byte that gives no result
// (opening quote, first quote of a pair) is consumed but produces no output
// transfer. The user must write the separator and quote bytes over the APB
// port at 0x0 and 0x4 only while the stream is idle; the block does not enforce it.
// The field index saturates at the smaller of MAX_FIELDS-1 and 255.
module csv_field_tokenizer_top #(
	parameter int unsigned MAX_FIELDS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tuser,   // [0] end_of_stream
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] field_number
	output logic [3:0]  m_tuser,   // [2:0] event_kind, [3] record_incomplete
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [7:0] CNT_LIMIT =
		(MAX_FIELDS - 1 > 255) ? 8'd255 : 8'(MAX_FIELDS - 1);

	// configuration registers
	logic [7:0] sep_q;
	logic [7:0] quote_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q   <= csvft_pkg::SEPARATOR_RESET;
			quote_q <= csvft_pkg::QUOTE_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				csvft_pkg::REG_SEPARATOR: sep_q   <= pwdata[7:0];
				csvft_pkg::REG_QUOTE:     quote_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			csvft_pkg::REG_SEPARATOR: prdata = {24'd0, sep_q};
			csvft_pkg::REG_QUOTE:     prdata = {24'd0, quote_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;
	logic       adv;

	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eos_s1  <= s_tuser;
		end
	end

	// parse state
	csvft_pkg::mode_t mode_q, mode_d;
	logic [7:0]       cnt_q, cnt_d;
	logic             rec_q, rec_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= csvft_pkg::MODE_PLAIN;
			cnt_q  <= 8'd0;
			rec_q  <= 1'b0;
		end else if (adv) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			rec_q  <= rec_d;
		end
	end

	// plain-mode handling of the current byte
	csvft_pkg::mode_t plain_mode;
	csvft_pkg::kind_t plain_kind;
	logic             plain_emit;
	logic [7:0]       plain_byte;
	logic [7:0]       plain_cnt;
	logic             plain_rec;

	always_comb begin
		plain_mode = csvft_pkg::MODE_PLAIN;
		plain_kind = csvft_pkg::KIND_DATA;
		plain_emit = 1'b1;
		plain_byte = 8'd0;
		plain_cnt  = cnt_q;
		plain_rec  = 1'b1;
		// quote wins over newline, newline over separator
		if (byte_s1 == quote_q) begin
			plain_mode = csvft_pkg::MODE_QUOTED;
			plain_emit = 1'b0;
		end else if (byte_s1 == csvft_pkg::NEWLINE_BYTE) begin
			plain_kind = csvft_pkg::KIND_RECORD;
			plain_cnt  = 8'd0;
			plain_rec  = 1'b0;
		end else if (byte_s1 == sep_q) begin
			plain_kind = csvft_pkg::KIND_FIELD;
			if (cnt_q < CNT_LIMIT)
				plain_cnt = cnt_q + 8'd1;
		end else begin
			plain_byte = byte_s1;
		end
	end

	csvft_pkg::kind_t kind_d;
	logic             emit_d;
	logic [7:0]       obyte_d;
	logic             inc_d;

	always_comb begin
		mode_d  = mode_q;
		cnt_d   = cnt_q;
		rec_d   = rec_q;
		kind_d  = csvft_pkg::KIND_DATA;
		emit_d  = 1'b0;
		obyte_d = 8'd0;
		inc_d   = 1'b0;
		if (eos_s1) begin
			emit_d = 1'b1;
			if (mode_q == csvft_pkg::MODE_QUOTED) begin
				kind_d = csvft_pkg::KIND_ERROR;
			end else begin
				kind_d = csvft_pkg::KIND_STREAM;
				inc_d  = rec_q;
			end
			mode_d = csvft_pkg::MODE_PLAIN;
			cnt_d  = 8'd0;
			rec_d  = 1'b0;
		end else begin
			unique case (mode_q)
				csvft_pkg::MODE_QUOTED: begin
					if (byte_s1 == quote_q) begin
						mode_d = csvft_pkg::MODE_QSEEN;
					end else begin
						emit_d  = 1'b1;
						obyte_d = byte_s1;
					end
				end
				csvft_pkg::MODE_QSEEN: begin
					if (byte_s1 == quote_q) begin
						// doubled quote: literal quote, stay in the span
						mode_d  = csvft_pkg::MODE_QUOTED;
						emit_d  = 1'b1;
						obyte_d = byte_s1;
					end else begin
						mode_d  = plain_mode;
						cnt_d   = plain_cnt;
						rec_d   = plain_rec;
						kind_d  = plain_kind;
						emit_d  = plain_emit;
						obyte_d = plain_byte;
					end
				end
				default: begin
					mode_d  = plain_mode;
					cnt_d   = plain_cnt;
					rec_d   = plain_rec;
					kind_d  = plain_kind;
					emit_d  = plain_emit;
					obyte_d = plain_byte;
				end
			endcase
		end
	end

	// result register
	logic             m_tvalid_q;
	csvft_pkg::kind_t kind_q;
	logic [7:0]       obyte_q;
	logic [7:0]       fnum_q;
	logic             inc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= emit_d;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit_d) begin
			kind_q  <= kind_d;
			obyte_q <= obyte_d;
			fnum_q  <= cnt_q;
			inc_q   <= inc_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {fnum_q, obyte_q};
	assign m_tuser  = {inc_q, kind_q};

`ifndef SYNTHESIS
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && eos_s1) |=>
		(mode_q == csvft_pkg::MODE_PLAIN && cnt_q == 8'd0 && !rec_q))
		else $error("parse state not cleared after stream end");

	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_LIMIT)
		else $error("field counter beyond limit");

	a_inc_only_stream: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && inc_q) |-> (kind_q == csvft_pkg::KIND_STREAM))
		else $error("record_incomplete on a non stream-end result");

	a_byte_only_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && kind_q != csvft_pkg::KIND_DATA) |-> (obyte_q == 8'd0))
		else $error("out_byte set on a non-data result");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid_q |-> s_tready)
		else $error("input stalled with an empty result register");
`endif

endmodule
